// ===== design/gdbp_pkg.sv =====
package gdbp_pkg;

    // fixed field widths of the stream and register ports
    localparam int SIZE_W     = 16;
    localparam int BIN_W      = 6;
    localparam int FILL_W     = SIZE_W + 1;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // input selector codes (s_axis_tuser)
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // register index of bin_capacity and its reset value
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [SIZE_W-1:0] CAPACITY_RESET = 16'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PLACE,
        S_FLUSH,
        S_EMPTY
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // store the item on the input beat
        logic scan_init;  // rewind scan address, forget best candidate
        logic rd_en;      // read one store entry
        logic place;      // commit best candidate into the bin
        logic end_bin;    // close the bin, mark pending result
        logic flush;      // move pending result to output
        logic empty;      // emit the empty-set result
        logic clear_run;  // drop the item set after a run
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic total_zero;
        logic scan_last;
        logic found;
        logic pend_valid;
        logic out_free;
        logic all_placed;
    } t_stat;

endpackage

// ===== design/gdbp_ctrl.sv =====
module gdbp_ctrl
    import gdbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_cmd,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_cmd == CMD_START) begin
                    n_state = i_stat.total_zero ? S_EMPTY : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PLACE;
            end
            S_PLACE: begin
                if (i_stat.found) begin
                    if (!i_stat.pend_valid || i_stat.out_free) begin
                        n_state = S_SCAN;
                    end
                end else if (i_stat.all_placed) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_START) begin
                        o_cmd.scan_init = !i_stat.total_zero;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            S_DRAIN: begin
            end
            S_PLACE: begin
                if (i_stat.found) begin
                    if (!i_stat.pend_valid || i_stat.out_free) begin
                        o_cmd.place     = 1'b1;
                        o_cmd.scan_init = 1'b1;
                    end
                end else begin
                    o_cmd.end_bin   = 1'b1;
                    o_cmd.scan_init = !i_stat.all_placed;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.flush     = 1'b1;
                    o_cmd.clear_run = 1'b1;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.empty     = 1'b1;
                    o_cmd.clear_run = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // a run result is only flushed when one is pending
    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> i_stat.pend_valid)
        else $error("flush state without pending result");

    // loads are taken only while idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE && i_in_valid))
        else $error("load outside idle");

    // every scan pass ends in a placement decision
    a_drain_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_PLACE))
        else $error("drain not followed by place");

endmodule

// ===== design/gdbp_dp.sv =====
module gdbp_dp
    import gdbp_pkg::*;
#(
    parameter int MAX_ITEMS = 32,
    parameter int SIZE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [SIZE_W-1:0] i_item_size,
    input  logic [SIZE_W-1:0] i_capacity,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [BIN_W-1:0]  o_bin_number,
    output logic [SIZE_W-1:0] o_placed_size,
    output logic              o_end_of_bin,
    output logic              o_end_of_all,
    output logic              o_empty_set,
    output logic              o_load_overflow
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int LB    = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;

    // item store, one write and one registered read port
    logic [SIZE_BITS-1:0] r_mem [MAX_ITEMS];
    logic [SIZE_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_addr;

    // run state
    logic [MAX_ITEMS-1:0] r_marks;
    logic [CNT_W-1:0]     r_item_total;
    logic [CNT_W-1:0]     r_placed_total;
    logic [BIN_W-1:0]     r_bin_cnt;
    logic [FILL_W-1:0]    r_fill;
    logic                 r_ovf;
    logic                 r_open;

    // best candidate of the current scan
    logic                 r_best_found;
    logic [SIZE_W-1:0]    r_best_size;
    logic [IDX_W-1:0]     r_best_idx;

    // pending result, held until end_of_bin is known
    logic                 r_pend_valid;
    logic [BIN_W-1:0]     r_pend_bin;
    logic [SIZE_W-1:0]    r_pend_size;
    logic                 r_pend_eob;
    logic                 r_pend_eoa;

    // output register
    logic                 r_out_valid;
    logic [BIN_W-1:0]     r_out_bin;
    logic [SIZE_W-1:0]    r_out_size;
    logic                 r_out_eob;
    logic                 r_out_eoa;
    logic                 r_out_empty;
    logic                 r_out_ovf;

    logic                 load_ok;
    logic                 store_full;
    logic [SIZE_W-1:0]    rd_size;
    logic [FILL_W-1:0]    n_fill_try;
    logic                 eligible;
    logic                 better;
    logic                 out_free;
    logic                 out_load;
    logic [BIN_W-1:0]     n_bin;

    assign store_full = (r_item_total >= CNT_W'(MAX_ITEMS));
    assign load_ok    = i_cmd.load && (i_item_size[LB-1:0] != '0);
    assign rd_size    = SIZE_W'(r_rd_data[LB-1:0]);
    assign n_fill_try = r_fill + FILL_W'(rd_size);
    assign eligible   = !r_marks[r_rd_idx] &&
                        (r_open || n_fill_try <= FILL_W'(i_capacity));
    assign better     = !r_best_found || rd_size > r_best_size;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = i_cmd.flush || (i_cmd.place && r_pend_valid);
    assign n_bin      = r_open ? r_bin_cnt + 1'b1 : r_bin_cnt;

    // store write and scan read
    always_ff @(posedge i_clk) begin
        if (load_ok && !store_full) begin
            r_mem[r_item_total[IDX_W-1:0]] <= SIZE_BITS'(i_item_size[LB-1:0]);
        end
        r_rd_data <= r_mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    // scan address and read pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.scan_init) begin
                r_addr <= '0;
            end else if (i_cmd.rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    // best candidate: largest unplaced entry that fits (any size while the bin is empty), earliest wins a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_best_found <= 1'b0;
        end else if (r_rd_vld && eligible && better) begin
            r_best_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && eligible && better) begin
            r_best_size <= rd_size;
            r_best_idx  <= r_rd_idx;
        end
    end

    // item set and bin bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_run) begin
            r_marks        <= '0;
            r_item_total   <= '0;
            r_placed_total <= '0;
            r_bin_cnt      <= '0;
            r_fill         <= '0;
            r_ovf          <= 1'b0;
            r_open         <= 1'b1;
        end else begin
            if (load_ok) begin
                if (store_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_marks[r_item_total[IDX_W-1:0]] <= 1'b0;
                    r_item_total <= r_item_total + 1'b1;
                end
            end
            if (i_cmd.place) begin
                r_marks[r_best_idx] <= 1'b1;
                r_placed_total      <= r_placed_total + 1'b1;
                r_bin_cnt           <= n_bin;
                r_open              <= 1'b0;
                r_fill <= r_open ? FILL_W'(r_best_size) : r_fill + FILL_W'(r_best_size);
            end
            if (i_cmd.end_bin) begin
                r_open <= 1'b1;
            end
        end
    end

    // pending result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.place) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    // pending result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_pend_bin  <= n_bin;
            r_pend_size <= r_best_size;
            r_pend_eob  <= 1'b0;
            r_pend_eoa  <= 1'b0;
        end else if (i_cmd.end_bin) begin
            r_pend_eob <= 1'b1;
            r_pend_eoa <= (r_placed_total == r_item_total);
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load || i_cmd.empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_bin   <= r_pend_bin;
            r_out_size  <= r_pend_size;
            r_out_eob   <= r_pend_eob;
            r_out_eoa   <= r_pend_eoa;
            r_out_empty <= 1'b0;
            r_out_ovf   <= r_ovf;
        end else if (i_cmd.empty) begin
            r_out_bin   <= '0;
            r_out_size  <= '0;
            r_out_eob   <= 1'b0;
            r_out_eoa   <= 1'b1;
            r_out_empty <= 1'b1;
            r_out_ovf   <= r_ovf;
        end
    end

    // status to controller
    assign o_stat.total_zero = (r_item_total == '0);
    assign o_stat.scan_last  = (r_addr == IDX_W'(r_item_total - 1'b1));
    assign o_stat.found      = r_best_found;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;
    assign o_stat.all_placed = (r_placed_total == r_item_total);

    assign o_out_valid     = r_out_valid;
    assign o_bin_number    = r_out_bin;
    assign o_placed_size   = r_out_size;
    assign o_end_of_bin    = r_out_eob;
    assign o_end_of_all    = r_out_eoa;
    assign o_empty_set     = r_out_empty;
    assign o_load_overflow = r_out_ovf;

    // never more placements than items
    a_placed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_placed_total <= r_item_total)
        else $error("placed count exceeds item count");

    // a placement needs a candidate from the scan
    a_place_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> r_best_found)
        else $error("placement without candidate");

    // a pending result is only pushed into a free output register
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load || i_cmd.empty) |-> out_free)
        else $error("output register overwritten");

    // closing a bin always has its last placement pending
    a_end_bin_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.end_bin |-> r_pend_valid)
        else $error("bin closed with no pending result");

endmodule

// ===== design/greedy_decreasing_bin_packer.sv =====
// Load beats are taken one per cycle while idle; a zero size or a load into a full store is dropped.
// A start beat packs N loaded items: every placement and every bin close costs one scan
// of the item store through its single read port.
// s_axis_tready is low from a start until its last result is registered, also for an empty start.
// Reset (i_rst_n low, synchronous) empties the item set and sets bin_capacity to 10.
module greedy_decreasing_bin_packer
    import gdbp_pkg::*;
#(
    parameter int MAX_ITEMS = 32,
    parameter int SIZE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] item_size
    input  logic                   s_axis_tuser,   // [0] cmd
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] bin_number, [21:6] placed_size
    output logic                   m_axis_tlast,   // end_of_all
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] end_of_bin, [1] empty_set,
                                                   // [2] load_overflow
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_cmd              cmd;
    t_stat             stat;
    logic [SIZE_W-1:0] r_bin_capacity;
    logic              cap_sel;
    logic [BIN_W-1:0]  bin_number;
    logic [SIZE_W-1:0] placed_size;
    logic              end_of_bin;
    logic              empty_set;
    logic              load_overflow;

    // bin_capacity register
    assign cap_sel = (paddr[2] == REG_CAPACITY);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? APB_DW'(r_bin_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_bin_capacity <= pwdata[SIZE_W-1:0];
        end
    end

    gdbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    gdbp_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_item_size     (s_axis_tdata[SIZE_W-1:0]),
        .i_capacity      (r_bin_capacity),
        .i_out_ready     (m_axis_tready),
        .o_stat          (stat),
        .o_out_valid     (m_axis_tvalid),
        .o_bin_number    (bin_number),
        .o_placed_size   (placed_size),
        .o_end_of_bin    (end_of_bin),
        .o_end_of_all    (m_axis_tlast),
        .o_empty_set     (empty_set),
        .o_load_overflow (load_overflow)
    );

    // result packing
    assign m_axis_tdata = {2'b00, placed_size, bin_number};
    assign m_axis_tuser = {load_overflow, empty_set, end_of_bin};

endmodule
